// ===== hw/rtl/wgm_pkg.sv =====
// wgm_pkg: shared types, constants and helper functions of the wildcard glob matcher
`timescale 1ns / 1ps

package wgm_pkg;

  // pattern capacity and derived widths
  localparam int unsigned MaxPattern = 32;
  localparam int unsigned LenW       = $clog2(MaxPattern + 1);
  localparam int unsigned IdxW       = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

  // special pattern bytes
  localparam logic [7:0] StarCode = 8'd42;
  localparam logic [7:0] AnyCode  = 8'd63;

  // request kinds
  typedef enum logic [0:0] {
    CmdPattern = 1'b0,
    CmdText    = 1'b1
  } cmd_e;

  // input request
  typedef struct packed {
    cmd_e       command;
    logic [7:0] char_code;
    logic       last;
  } in_req_t;

  // result
  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_rsp_t;

  // stored pattern view
  typedef logic [MaxPattern-1:0][7:0] pattern_t;
  typedef logic [MaxPattern-1:0]      column_t;

  // state seen by the column update
  typedef struct packed {
    pattern_t        pattern;
    logic [LenW-1:0] length;
    column_t         column;
    logic            text_empty;
    logic [7:0]      char_code;
  } col_in_t;

  // the two candidate columns
  typedef struct packed {
    column_t text_col;
    column_t restart_col;
  } col_out_t;

  // v[j] = gen[j] | (prop[j] & v[j-1]), solved as the carries of one add
  function automatic column_t chain_or(input column_t gen, input column_t prop);
    logic [MaxPattern:0] a;
    logic [MaxPattern:0] b;
    logic [MaxPattern:0] s;
    logic [MaxPattern:0] c;
    a = {1'b0, gen | prop};
    b = {1'b0, gen};
    s = a + b;
    c = s ^ a ^ b;
    return c[MaxPattern:1];
  endfunction

  // table entry for pattern prefix len
  function automatic logic column_bit(input logic [LenW-1:0] len, input column_t col,
                                      input logic text_empty);
    logic [LenW-1:0] pos;
    pos = len - LenW'(1);
    if (len == '0) begin
      return text_empty;
    end
    return col[pos[IdxW-1:0]];
  endfunction

endpackage

// ===== hw/rtl/wgm_column.sv =====
// wgm_column: next match column for a text byte and the column for an empty text
`timescale 1ns / 1ps

module wgm_column (
  input  wgm_pkg::col_in_t  col_i,
  output wgm_pkg::col_out_t col_o
);

  wgm_pkg::column_t valid;
  wgm_pkg::column_t star;
  wgm_pkg::column_t hit;
  wgm_pkg::column_t prev;
  wgm_pkg::column_t text_gen;
  wgm_pkg::column_t text_prop;
  wgm_pkg::column_t rst_gen;
  logic [wgm_pkg::MaxPattern:0] col_ext;

  // per-position decode of the pattern bytes
  always_comb begin
    for (int unsigned j = 0; j < wgm_pkg::MaxPattern; j++) begin
      valid[j] = wgm_pkg::LenW'(j) < col_i.length;
      star[j]  = col_i.pattern[j] == wgm_pkg::StarCode;
      hit[j]   = (col_i.pattern[j] == wgm_pkg::AnyCode) ||
                 (col_i.pattern[j] == col_i.char_code);
    end
  end

  // entry for the prefix one shorter, empty prefix at the bottom
  assign col_ext = {col_i.column, col_i.text_empty};
  assign prev    = col_ext[wgm_pkg::MaxPattern-1:0];

  // text byte: star takes the entry beside or below, others the diagonal
  assign text_gen  = valid & ((star & col_i.column) | (~star & hit & prev));
  assign text_prop = valid & star;

  // empty text: leading run of stars
  assign rst_gen = valid & star & wgm_pkg::column_t'(1);

  assign col_o.text_col    = wgm_pkg::chain_or(text_gen, text_prop);
  assign col_o.restart_col = wgm_pkg::chain_or(rst_gen, text_prop);

endmodule

// ===== hw/rtl/wgm_store.sv =====
// wgm_store: pattern storage, match state and result of one request
`timescale 1ns / 1ps

module wgm_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  wgm_pkg::in_req_t  req_i,
  output wgm_pkg::out_rsp_t rsp_o
);

  wgm_pkg::pattern_t        pattern_q;
  logic [wgm_pkg::LenW-1:0] length_q, length_d;
  logic                     complete_q, complete_d;
  logic                     overflow_q, overflow_d;
  wgm_pkg::column_t         column_q, column_d;
  logic                     text_empty_q, text_empty_d;

  logic                     is_pattern;
  logic [wgm_pkg::LenW-1:0] len_base;
  logic                     ovf_base;
  logic                     has_room;
  logic                     pat_we;
  logic [wgm_pkg::IdxW-1:0] wr_idx;
  wgm_pkg::pattern_t        pattern_eff;
  wgm_pkg::col_in_t         col_in;
  wgm_pkg::col_out_t        col_out;

  // a pattern request after a complete pattern starts over
  assign is_pattern = req_i.command == wgm_pkg::CmdPattern;
  assign len_base   = complete_q ? '0 : length_q;
  assign ovf_base   = complete_q ? 1'b0 : overflow_q;
  assign has_room   = len_base < wgm_pkg::LenW'(wgm_pkg::MaxPattern);
  assign pat_we     = is_pattern && has_room;
  assign wr_idx     = len_base[wgm_pkg::IdxW-1:0];

  // pattern as it stands after this request
  always_comb begin
    pattern_eff = pattern_q;
    if (pat_we) begin
      pattern_eff[wr_idx] = req_i.char_code;
    end
  end

  // next control state
  always_comb begin
    length_d   = length_q;
    complete_d = complete_q;
    overflow_d = overflow_q;
    if (is_pattern) begin
      length_d   = has_room ? len_base + wgm_pkg::LenW'(1) : len_base;
      overflow_d = ovf_base || !has_room;
      complete_d = req_i.last;
    end
  end

  // column update
  assign col_in.pattern    = pattern_eff;
  assign col_in.length     = length_d;
  assign col_in.column     = column_q;
  assign col_in.text_empty = text_empty_q;
  assign col_in.char_code  = req_i.char_code;

  wgm_column u_column (
    .col_i (col_in),
    .col_o (col_out)
  );

  // next column and result
  always_comb begin
    if (is_pattern || req_i.last) begin
      column_d     = col_out.restart_col;
      text_empty_d = 1'b1;
    end else begin
      column_d     = col_out.text_col;
      text_empty_d = 1'b0;
    end
    if (is_pattern) begin
      rsp_o.matched = wgm_pkg::column_bit(length_d, col_out.restart_col, 1'b1) && !overflow_d;
    end else begin
      rsp_o.matched = wgm_pkg::column_bit(length_d, col_out.text_col, 1'b0) && !overflow_d;
    end
    rsp_o.pattern_overflow = overflow_d;
  end

  // pattern bytes
  always_ff @(posedge clk_i) begin
    if (fire_i && pat_we) begin
      pattern_q[wr_idx] <= req_i.char_code;
    end
  end

  // match state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q     <= '0;
      complete_q   <= 1'b0;
      overflow_q   <= 1'b0;
      column_q     <= '0;
      text_empty_q <= 1'b1;
    end else if (fire_i) begin
      length_q     <= length_d;
      complete_q   <= complete_d;
      overflow_q   <= overflow_d;
      column_q     <= column_d;
      text_empty_q <= text_empty_d;
    end
  end

endmodule

// ===== hw/rtl/wildcard_glob_matcher.sv =====
// wildcard_glob_matcher: top level with request register and result register
// path: an accepted request is held in the request register, and its result then in the result register
// throughput: one request per cycle while the output is not stalled; the match column updates in a single pass
// between the request register and the result register
// reset: pattern empty, text empty, no overflow; pattern bytes are not cleared
`timescale 1ns / 1ps

module wildcard_glob_matcher (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wgm_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wgm_pkg::out_rsp_t out_rsp_o
);

  logic              in_valid_q, in_valid_d;
  wgm_pkg::in_req_t  in_req_q;
  logic              out_valid_q, out_valid_d;
  wgm_pkg::out_rsp_t out_rsp_q;
  wgm_pkg::out_rsp_t rsp;
  logic              out_free;
  logic              fire;
  logic              in_acc;

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_acc ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = fire ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  // matcher state and result logic
  wgm_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_req_q),
    .rsp_o  (rsp)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and result payloads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_req_q <= in_req_i;
    end
    if (fire) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
